// File: rtl/ntcu_pkg.sv
//------------------------------------------------------------------------------
// ntcu_pkg
// shared codes and field widths for the numeric type conversion unit
//------------------------------------------------------------------------------
`default_nettype none

package ntcu_pkg;

	localparam int unsigned BitsW = 64;
	localparam int unsigned FuncW = 3;
	localparam int unsigned TagW  = 2;
	localparam int unsigned ErrW  = 3;
	localparam int unsigned InDataW  = 136;
	localparam int unsigned OutDataW = 72;

	typedef enum logic [FuncW-1:0] {
		FN_BITS     = 3'd0,
		FN_POSITIVE = 3'd1,
		FN_NEGATIVE = 3'd2,
		FN_INTEGRAL = 3'd3,
		FN_TO_DBL   = 3'd4,
		FN_WIDE     = 3'd5
	} func_t;

	localparam logic [TagW-1:0] TAG_SIGNED   = 2'd0;
	localparam logic [TagW-1:0] TAG_UNSIGNED = 2'd1;
	localparam logic [TagW-1:0] TAG_DOUBLE   = 2'd2;

	localparam logic [ErrW-1:0] ERR_OK           = 3'd0;
	localparam logic [ErrW-1:0] ERR_NOT_POSITIVE = 3'd1;
	localparam logic [ErrW-1:0] ERR_NOT_NEGATIVE = 3'd2;
	localparam logic [ErrW-1:0] ERR_TOO_LARGE    = 3'd3;
	localparam logic [ErrW-1:0] ERR_NOT_INTEGRAL = 3'd4;
	localparam logic [ErrW-1:0] ERR_NAN          = 3'd5;

	localparam logic [10:0] EXP_MAX  = 11'h7ff;
	localparam logic [10:0] EXP_BIAS = 11'd1023;

endpackage

`default_nettype wire

// File: rtl/numeric_type_conversion_unit.sv
//------------------------------------------------------------------------------
// numeric_type_conversion_unit
// integer / double conversions with range and integrality checks
//------------------------------------------------------------------------------
// channel   dir  tdata fields (low bit first)
// s_axis    in   func[2:0] in_tag[4:3] in_bits[68:5] wide_high[132:69]
//                wide_signed[133] prefer_signed[134]
// m_axis    out  out_tag[1:0] out_bits[65:2] error[68:66]
//
// four register stages; one word enters per cycle while the output is not stalled
// s1: decode, operand negation, double field checks
// s2: leading-one search, double-to-integer shift
// s3: normalizing shift, round bits; s4: rounding add and result select
// a stall freezes every stage at once; the output stage holds its word
// arst_n clears the valid bits only
//------------------------------------------------------------------------------
`default_nettype none

module numeric_type_conversion_unit
	import ntcu_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_axis_tvalid,
	output logic                     s_axis_tready,
	input  wire logic [InDataW-1:0]  s_axis_tdata,  // func, in_tag, in_bits, wide_high, wide_signed, prefer_signed
	output logic                     m_axis_tvalid,
	input  wire logic                m_axis_tready,
	output logic [OutDataW-1:0]      m_axis_tdata   // out_tag, out_bits, error
);

	logic adv;
	assign adv = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = adv;

	// input unpack
	logic [2:0]  func;
	logic [1:0]  in_tag;
	logic [63:0] in_bits, wide_high;
	logic        wide_signed, prefer_signed;
	assign func          = s_axis_tdata[2:0];
	assign in_tag        = s_axis_tdata[4:3];
	assign in_bits       = s_axis_tdata[68:5];
	assign wide_high     = s_axis_tdata[132:69];
	assign wide_signed   = s_axis_tdata[133];
	assign prefer_signed = s_axis_tdata[134];

	// ---------------- stage 1 ----------------
	// kind of work left for later stages
	typedef enum logic [1:0] {K_DIRECT, K_DBL2INT, K_INT2DBL} kind_t;

	kind_t        k0;
	logic [1:0]   t0;
	logic [63:0]  b0;
	logic [2:0]   e0;
	logic         neg0;
	logic [127:0] mag0;
	logic         chkneg0;   // double-to-int takes negative path
	logic [10:0]  ex0;
	logic [51:0]  fr0;

	logic         isdbl;
	logic [10:0]  de;
	logic [51:0]  df;
	logic         ds, dnan, dzero, dinf;
	logic [63:0]  xneg;
	logic [127:0] wneg;
	logic         wfits;

	assign isdbl = in_tag[1];
	assign de = in_bits[62:52];
	assign df = in_bits[51:0];
	assign ds = in_bits[63];
	assign dnan  = (de == EXP_MAX) && (df != '0);
	assign dinf  = (de == EXP_MAX) && (df == '0);
	assign dzero = (de == '0) && (df == '0);
	assign xneg = 64'd0 - in_bits;
	assign wneg = 128'd0 - {wide_high, in_bits};
	assign wfits = (wide_high == '0) || ((wide_high == '1) && in_bits[63]);

	// double-to-integer checks not needing the shift
	function automatic logic [2:0] dbl_pre(input logic neg_path, input logic s,
			input logic nan, input logic zero, input logic inf,
			input logic [10:0] e, input logic [51:0] f);
		logic [2:0] r;
		r = ERR_OK;
		if (nan) r = ERR_NOT_INTEGRAL;
		else if ((neg_path ? !s : s) || zero)
			r = neg_path ? ERR_NOT_NEGATIVE : ERR_NOT_POSITIVE;
		else if (inf) r = ERR_TOO_LARGE;
		else if (e < EXP_BIAS) r = ERR_NOT_INTEGRAL;
		else if (neg_path && ((e - EXP_BIAS > 11'd63) ||
				((e - EXP_BIAS == 11'd63) && (f != '0))))
			r = ERR_TOO_LARGE;
		else if (!neg_path && (e - EXP_BIAS >= 11'd64)) r = ERR_TOO_LARGE;
		return r;
	endfunction

	always_comb begin
		k0 = K_DIRECT; t0 = TAG_SIGNED; b0 = '0; e0 = ERR_OK;
		neg0 = 1'b0; mag0 = '0; chkneg0 = 1'b0; ex0 = de; fr0 = df;
		case (func)
			FN_BITS: begin
				t0 = TAG_UNSIGNED; b0 = in_bits;
			end
			FN_POSITIVE: begin
				t0 = TAG_UNSIGNED;
				if (isdbl) begin
					k0 = K_DBL2INT; chkneg0 = 1'b0;
					e0 = dbl_pre(1'b0, ds, dnan, dzero, dinf, de, df);
				end else if (in_bits == '0 || (in_tag == TAG_SIGNED && in_bits[63]))
					e0 = ERR_NOT_POSITIVE;
				else b0 = in_bits;
			end
			FN_NEGATIVE: begin
				t0 = TAG_SIGNED;
				if (isdbl) begin
					k0 = K_DBL2INT; chkneg0 = 1'b1;
					e0 = dbl_pre(1'b1, ds, dnan, dzero, dinf, de, df);
				end else if (in_tag == TAG_SIGNED && in_bits[63]) b0 = in_bits;
				else e0 = ERR_NOT_NEGATIVE;
			end
			FN_INTEGRAL: begin
				if (!isdbl) begin
					t0 = in_tag; b0 = in_bits;
				end else if (dnan) e0 = ERR_NAN;
				else if (dzero) t0 = TAG_UNSIGNED;
				else begin
					k0 = K_DBL2INT; chkneg0 = ds;
					t0 = ds ? TAG_SIGNED : TAG_UNSIGNED;
					e0 = dbl_pre(ds, ds, dnan, dzero, dinf, de, df);
				end
			end
			FN_TO_DBL: begin
				t0 = TAG_DOUBLE;
				if (isdbl) b0 = in_bits;
				else begin
					k0 = K_INT2DBL;
					neg0 = (in_tag == TAG_SIGNED) && in_bits[63];
					mag0 = {64'd0, neg0 ? xneg : in_bits};
				end
			end
			FN_WIDE: begin
				if (!wide_signed) begin
					if (wide_high != '0) begin
						t0 = TAG_DOUBLE; k0 = K_INT2DBL;
						mag0 = {wide_high, in_bits};
					end else begin
						t0 = TAG_UNSIGNED; b0 = in_bits;
					end
				end else if (!wfits) begin
					t0 = TAG_DOUBLE; k0 = K_INT2DBL;
					neg0 = wide_high[63];
					mag0 = neg0 ? wneg : {wide_high, in_bits};
				end else begin
					b0 = in_bits;
					if (wide_high[63]) t0 = TAG_SIGNED;
					else if (prefer_signed) t0 = in_bits[63] ? TAG_UNSIGNED : TAG_SIGNED;
					else t0 = TAG_UNSIGNED;
				end
			end
			default: ;
		endcase
	end

	logic         v_s1, v_s2, v_s3, v_s4;
	kind_t        k_s1, k_s2, k_s3;
	logic [1:0]   t_s1, t_s2, t_s3;
	logic [63:0]  b_s1, b_s2, b_s3;
	logic [2:0]   e_s1, e_s2, e_s3;
	logic         neg_s1, neg_s2, neg_s3;
	logic [127:0] mag_s1, mag_s2;
	logic         cn_s1;
	logic [10:0]  ex_s1;
	logic [51:0]  fr_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= s_axis_tvalid; v_s2 <= v_s1; v_s3 <= v_s2; v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			k_s1 <= k0; t_s1 <= t0; b_s1 <= b0; e_s1 <= e0; neg_s1 <= neg0;
			mag_s1 <= mag0; cn_s1 <= chkneg0; ex_s1 <= ex0; fr_s1 <= fr0;
		end
	end

	// ---------------- stage 2 ----------------
	logic [6:0]  p1;
	logic [63:0] b1;
	logic [2:0]  e1;
	logic [52:0] mant1;
	logic [5:0]  ue1;
	logic [63:0] shl1, shr1;
	logic [52:0] lostmask1;

	always_comb begin
		p1 = '0;
		for (int i = 0; i < 128; i++)
			if (mag_s1[i]) p1 = 7'(i);
	end

	always_comb begin
		mant1 = {1'b1, fr_s1};
		ue1 = 6'(ex_s1 - EXP_BIAS);
		shl1 = {11'd0, mant1} << ((ue1 >= 6'd52) ? (ue1 - 6'd52) : 6'd0);
		shr1 = {11'd0, mant1} >> ((ue1 < 6'd52) ? (6'd52 - ue1) : 6'd0);
		lostmask1 = (53'd1 << ((ue1 < 6'd52) ? (6'd52 - ue1) : 6'd0)) - 53'd1;
		b1 = b_s1; e1 = e_s1;
		if (k_s1 == K_DBL2INT && e_s1 == ERR_OK) begin
			if (ue1 >= 6'd52) b1 = shl1;
			else if ((mant1 & lostmask1) != '0) e1 = ERR_NOT_INTEGRAL;
			else b1 = shr1;
			if (cn_s1) b1 = 64'd0 - b1;
		end
	end

	logic [6:0] p_s2;
	always_ff @(posedge clk) begin
		if (adv) begin
			k_s2 <= k_s1; t_s2 <= t_s1; b_s2 <= b1; e_s2 <= e1;
			neg_s2 <= neg_s1; mag_s2 <= mag_s1; p_s2 <= p1;
		end
	end

	// ---------------- stage 3 ----------------
	// left-align leading one to bit 127, then take 53 mantissa bits
	logic [127:0] al2;
	logic [52:0]  m2;
	logic         g2, st2;
	assign al2 = mag_s2 << (7'd127 - p_s2);
	assign m2  = al2[127:75];
	assign g2  = al2[74];
	assign st2 = al2[73:0] != '0;

	logic [52:0] m_s3;
	logic        g_s3, st_s3, z_s3;
	logic [6:0]  p_s3;
	always_ff @(posedge clk) begin
		if (adv) begin
			k_s3 <= k_s2; t_s3 <= t_s2; b_s3 <= b_s2; e_s3 <= e_s2;
			neg_s3 <= neg_s2; m_s3 <= m2; g_s3 <= g2; st_s3 <= st2;
			p_s3 <= p_s2; z_s3 <= (mag_s2 == '0);
		end
	end

	// ---------------- stage 4 ----------------
	logic [53:0] mr3;
	logic [10:0] exp3;
	logic [63:0] dbl3, b3;
	logic [1:0]  t3;
	always_comb begin
		mr3 = {1'b0, m_s3} + 54'(g_s3 && (st_s3 || m_s3[0]));
		exp3 = 11'(p_s3) + EXP_BIAS + 11'(mr3[53]);
		dbl3 = z_s3 ? 64'd0 :
			{neg_s3, exp3, (mr3[53] ? mr3[52:1] : mr3[51:0])};
		b3 = (k_s3 == K_INT2DBL) ? dbl3 : b_s3;
		t3 = t_s3;
		if (e_s3 != ERR_OK) begin
			b3 = '0; t3 = TAG_SIGNED;
		end
	end

	logic [1:0]  t_s4;
	logic [63:0] b_s4;
	logic [2:0]  e_s4;
	always_ff @(posedge clk) begin
		if (adv) begin
			t_s4 <= t3; b_s4 <= b3; e_s4 <= e_s3;
		end
	end

	assign m_axis_tvalid = v_s4;
	assign m_axis_tdata  = {3'd0, e_s4, b_s4, t_s4};

endmodule

`default_nettype wire
